### design/dtti_pkg.sv
// shared types and constants for the decimal text to integer block
`default_nettype none

package dtti_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;

    typedef enum logic [1:0] {
        MODE_S64 = 2'd0,
        MODE_U64 = 2'd1,
        MODE_S32 = 2'd2,
        MODE_U32 = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CLS_DIGIT,
        CLS_MINUS,
        CLS_PLUS,
        CLS_BAD
    } char_class_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       last_char;
        logic [1:0] mode;
    } in_t;

    typedef struct packed {
        logic               ok;
        logic signed [63:0] number;
    } out_t;

    typedef struct packed {
        char_class_t cls;
        logic [3:0]  digit;
        logic        last_char;
        mode_t       mode;
    } entry_t;

endpackage

`default_nettype wire

### design/dtti_front.sv
// front end: classifies each incoming character and tracks the first character of a string
`default_nettype none

module dtti_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire dtti_pkg::in_t in_item,
    input  wire logic          take,
    output dtti_pkg::entry_t   entry
);

    logic first_reg;
    logic first_next;
    logic is_digit;
    logic sign_ok;
    logic [7:0] digit_full;
    dtti_pkg::mode_t mode_in;

    assign mode_in    = dtti_pkg::mode_t'(in_item.mode);
    assign is_digit   = (in_item.char_in >= dtti_pkg::CHAR_ZERO)
                     && (in_item.char_in <= dtti_pkg::CHAR_NINE);
    assign sign_ok    = first_reg && (mode_in != dtti_pkg::MODE_U64)
                     && (mode_in != dtti_pkg::MODE_U32);
    assign digit_full = in_item.char_in - dtti_pkg::CHAR_ZERO;
    assign first_next = take ? in_item.last_char : first_reg;

    always_comb
    begin
        entry.digit     = digit_full[3:0];
        entry.last_char = in_item.last_char;
        entry.mode      = mode_in;
        if (is_digit)
        begin
            entry.cls = dtti_pkg::CLS_DIGIT;
        end
        else if (sign_ok && (in_item.char_in == dtti_pkg::CHAR_MINUS))
        begin
            entry.cls = dtti_pkg::CLS_MINUS;
        end
        else if (sign_ok && (in_item.char_in == dtti_pkg::CHAR_PLUS))
        begin
            entry.cls = dtti_pkg::CLS_PLUS;
        end
        else
        begin
            entry.cls = dtti_pkg::CLS_BAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
        end
        else
        begin
            first_reg <= first_next;
        end
    end

endmodule

`default_nettype wire

### design/dtti_queue.sv
// small fifo of classified characters between front and back
`default_nettype none

module dtti_queue #(
    parameter int DEPTH = dtti_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    input  wire dtti_pkg::entry_t wr_data,
    output logic                  rd_valid,
    input  wire logic             rd_ready,
    output dtti_pkg::entry_t      rd_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    dtti_pkg::entry_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic push;
    logic pop;

    assign wr_ready = (count_reg != CNT_FULL);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### design/dtti_back.sv
// back end: accumulates digits, then range-checks and registers the result
`default_nettype none

module dtti_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_valid,
    output logic                  q_ready,
    input  wire dtti_pkg::entry_t q_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output dtti_pkg::out_t        out_data
);

    typedef enum logic [1:0] {
        PH_START,
        PH_SIGN,
        PH_DIGITS,
        PH_FAIL
    } phase_t;

    localparam logic [62:0] S32_POS_MAX = 63'h0000_0000_7fff_ffff;
    localparam logic [62:0] S32_NEG_MAX = 63'h0000_0000_8000_0000;
    localparam logic [62:0] U32_MAX     = 63'h0000_0000_ffff_ffff;

    phase_t          phase_reg, phase_next;
    logic [62:0]     acc_reg, acc_next;
    logic            ovf_reg, ovf_next;
    logic            neg_reg, neg_next;
    dtti_pkg::mode_t mode_reg, mode_next;

    logic            fin_valid_reg, fin_valid_next;
    logic            fin_good_reg, fin_good_next;
    logic [62:0]     fin_acc_reg, fin_acc_next;
    logic            fin_neg_reg, fin_neg_next;
    dtti_pkg::mode_t fin_mode_reg, fin_mode_next;

    logic            out_valid_reg, out_valid_next;
    dtti_pkg::out_t  out_data_reg, out_data_next;

    logic        pop;
    logic        fin_move;
    logic        fin_free;
    logic        start;
    logic [62:0] cur_acc;
    logic        cur_ovf;
    logic [66:0] prod;
    logic        in_range;
    phase_t      step_phase;
    logic [62:0] step_acc;
    logic        step_ovf;
    logic        step_neg;

    assign fin_move  = fin_valid_reg && (!out_valid_reg || out_ready);
    assign fin_free  = !fin_valid_reg || fin_move;
    assign q_ready   = !q_data.last_char || fin_free;
    assign pop       = q_valid && q_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign start   = (phase_reg == PH_START);
    assign cur_acc = start ? '0 : acc_reg;
    assign cur_ovf = start ? 1'b0 : ovf_reg;
    assign prod    = ({4'b0, cur_acc} << 3) + ({4'b0, cur_acc} << 1)
                   + {63'b0, q_data.digit};

    always_comb
    begin
        step_phase = PH_FAIL;
        step_acc   = cur_acc;
        step_ovf   = cur_ovf;
        step_neg   = start ? 1'b0 : neg_reg;
        if (q_data.cls == dtti_pkg::CLS_DIGIT && phase_reg != PH_FAIL)
        begin
            step_phase = PH_DIGITS;
            if (!cur_ovf)
            begin
                if (|prod[66:63])
                begin
                    step_ovf = 1'b1;
                end
                else
                begin
                    step_acc = prod[62:0];
                end
            end
        end
        else if (start && (q_data.cls == dtti_pkg::CLS_MINUS
                        || q_data.cls == dtti_pkg::CLS_PLUS))
        begin
            step_phase = PH_SIGN;
            step_neg   = (q_data.cls == dtti_pkg::CLS_MINUS);
        end
    end

    always_comb
    begin
        unique case (fin_mode_reg)
            dtti_pkg::MODE_S32: in_range = fin_neg_reg ? (fin_acc_reg <= S32_NEG_MAX)
                                                       : (fin_acc_reg <= S32_POS_MAX);
            dtti_pkg::MODE_U32: in_range = (fin_acc_reg <= U32_MAX);
            default:            in_range = 1'b1;
        endcase
    end

    always_comb
    begin
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        ovf_next       = ovf_reg;
        neg_next       = neg_reg;
        mode_next      = mode_reg;
        fin_valid_next = fin_valid_reg && !fin_move;
        fin_good_next  = fin_good_reg;
        fin_acc_next   = fin_acc_reg;
        fin_neg_next   = fin_neg_reg;
        fin_mode_next  = fin_mode_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;

        if (pop)
        begin
            if (start)
            begin
                mode_next = q_data.mode;
            end
            if (q_data.last_char)
            begin
                phase_next     = PH_START;
                acc_next       = '0;
                ovf_next       = 1'b0;
                neg_next       = 1'b0;
                fin_valid_next = 1'b1;
                fin_good_next  = (step_phase == PH_DIGITS) && !step_ovf;
                fin_acc_next   = step_acc;
                fin_neg_next   = step_neg;
                fin_mode_next  = start ? q_data.mode : mode_reg;
            end
            else
            begin
                phase_next = step_phase;
                acc_next   = step_acc;
                ovf_next   = step_ovf;
                neg_next   = step_neg;
            end
        end

        if (fin_move)
        begin
            out_valid_next = 1'b1;
            out_data_next.ok = fin_good_reg && in_range;
            if (fin_good_reg && in_range)
            begin
                out_data_next.number = fin_neg_reg ? -$signed({1'b0, fin_acc_reg})
                                                   : $signed({1'b0, fin_acc_reg});
            end
            else
            begin
                out_data_next.number = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            neg_reg       <= 1'b0;
            mode_reg      <= dtti_pkg::MODE_S64;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            ovf_reg       <= ovf_next;
            neg_reg       <= neg_next;
            mode_reg      <= mode_next;
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fin_good_reg <= fin_good_next;
        fin_acc_reg  <= fin_acc_next;
        fin_neg_reg  <= fin_neg_next;
        fin_mode_reg <= fin_mode_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

### design/decimal_text_to_integer.sv
// top level of the streaming decimal text to integer converter
//
//  channel | signals                       | moves
//  --------+-------------------------------+---------------------------------
//  input   | in_valid, in_ready, in_data   | one character, last flag, mode
//  output  | out_valid, out_ready, out_data| ok and 64-bit value per string
//
// one character per cycle sustained while the output does not stall; the
// digit accumulate (times ten plus digit with overflow check) sets that
// figure. out_valid for a string rises once its last character has passed
// from the queue through the finish stage and the output register has loaded.
// reset clears the queue and parse state; a stalled output backs up into the
// queue and then drops in_ready.
`default_nettype none

module decimal_text_to_integer #(
    parameter int QUEUE_DEPTH = dtti_pkg::QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire dtti_pkg::in_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output dtti_pkg::out_t     out_data
);

    dtti_pkg::entry_t front_entry;
    dtti_pkg::entry_t q_data;
    logic             q_valid;
    logic             q_ready;
    logic             take;

    assign take = in_valid && in_ready;

    dtti_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_data),
        .take    (take),
        .entry   (front_entry)
    );

    dtti_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (in_valid),
        .wr_ready (in_ready),
        .wr_data  (front_entry),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_data)
    );

    dtti_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

### tb/testbench.sv
// self-checking testbench for the decimal text to integer converter
`default_nettype none

module testbench;

    typedef enum logic [1:0] {
        AT_START,
        AFTER_SIGN,
        IN_DIGITS,
        FAILED
    } parse_phase_t;

    typedef struct {
        logic [7:0]      ch;
        bit              last;
        dtti_pkg::mode_t mode;
        bit              typed;
        bit              ok;
        longint          num;
    } step_row_t;

    localparam int RANDOM_CHARS = 1450;
    localparam int DIRECTED_ROWS = 22;
    localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    dtti_pkg::in_t  in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    dtti_pkg::out_t out_data;

    parse_phase_t    phase;
    logic [63:0]     magnitude;
    bit              overflowed;
    bit              negative;
    dtti_pkg::mode_t string_mode;

    dtti_pkg::out_t expected_results[$];
    dtti_pkg::out_t oldest;
    int   error_count = 0;
    int   chars_sent = 0;
    bit   steady = 1'b0;

    step_row_t directed [DIRECTED_ROWS] = '{
        '{dtti_pkg::CHAR_ZERO, 1'b1, dtti_pkg::MODE_S64, 1'b1, 1'b1, 0},
        '{dtti_pkg::CHAR_NINE, 1'b1, dtti_pkg::MODE_U32, 1'b1, 1'b1, 9},
        // negative and positive zero
        '{dtti_pkg::CHAR_MINUS, 1'b0, dtti_pkg::MODE_S64, 1'b0, 1'b0, 0},
        '{dtti_pkg::CHAR_ZERO, 1'b1, dtti_pkg::MODE_S64, 1'b1, 1'b1, 0},
        '{dtti_pkg::CHAR_PLUS, 1'b0, dtti_pkg::MODE_S32, 1'b0, 1'b0, 0},
        '{dtti_pkg::CHAR_ZERO, 1'b1, dtti_pkg::MODE_U64, 1'b1, 1'b1, 0},
        // lone sign
        '{dtti_pkg::CHAR_MINUS, 1'b1, dtti_pkg::MODE_S64, 1'b1, 1'b0, 0},
        // sign in unsigned mode
        '{dtti_pkg::CHAR_PLUS, 1'b0, dtti_pkg::MODE_U64, 1'b0, 1'b0, 0},
        '{8'h35, 1'b1, dtti_pkg::MODE_U64, 1'b1, 1'b0, 0},
        // sign after a digit
        '{8'h31, 1'b0, dtti_pkg::MODE_S64, 1'b0, 1'b0, 0},
        '{dtti_pkg::CHAR_MINUS, 1'b1, dtti_pkg::MODE_S64, 1'b1, 1'b0, 0},
        // non-digit, later digits consumed
        '{8'h00, 1'b0, dtti_pkg::MODE_S64, 1'b0, 1'b0, 0},
        '{8'h33, 1'b1, dtti_pkg::MODE_S64, 1'b1, 1'b0, 0},
        '{8'hFF, 1'b1, dtti_pkg::MODE_U64, 1'b1, 1'b0, 0},
        // leading zeros, mode changes after the first character
        '{dtti_pkg::CHAR_ZERO, 1'b0, dtti_pkg::MODE_S32, 1'b0, 1'b0, 0},
        '{dtti_pkg::CHAR_ZERO, 1'b0, dtti_pkg::MODE_U64, 1'b0, 1'b0, 0},
        '{8'h37, 1'b1, dtti_pkg::MODE_U32, 1'b1, 1'b1, 7},
        '{dtti_pkg::CHAR_MINUS, 1'b0, dtti_pkg::MODE_S32, 1'b0, 1'b0, 0},
        '{8'h34, 1'b0, dtti_pkg::MODE_U32, 1'b0, 1'b0, 0},
        '{8'h32, 1'b1, dtti_pkg::MODE_S64, 1'b0, 1'b0, 0},
        // neighbors of the digit range
        '{8'h2F, 1'b1, dtti_pkg::MODE_S64, 1'b1, 1'b0, 0},
        '{8'h3A, 1'b1, dtti_pkg::MODE_S32, 1'b1, 1'b0, 0}
    };

    decimal_text_to_integer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    function automatic void clear_string();
        phase = AT_START;
        magnitude = '0;
        overflowed = 1'b0;
        negative = 1'b0;
    endfunction

    function automatic void add_digit(input logic [7:0] ch);
        logic [63:0] d;
        d = 64'(ch - dtti_pkg::CHAR_ZERO);
        if (!overflowed)
        begin
            if (magnitude > (MAG_MAX - d) / 64'd10)
                overflowed = 1'b1;
            else
                magnitude = magnitude * 64'd10 + d;
        end
        phase = IN_DIGITS;
    endfunction

    function automatic bit parse_char(input dtti_pkg::in_t item,
                                      output dtti_pkg::out_t res);
        bit is_digit;
        bit is_sign;
        bit signed_mode;
        bit good;
        is_digit = item.char_in >= dtti_pkg::CHAR_ZERO
                && item.char_in <= dtti_pkg::CHAR_NINE;
        res = '0;
        if (phase == AT_START)
        begin
            string_mode = dtti_pkg::mode_t'(item.mode);
            is_sign = item.char_in == dtti_pkg::CHAR_MINUS
                   || item.char_in == dtti_pkg::CHAR_PLUS;
            signed_mode = string_mode == dtti_pkg::MODE_S64
                       || string_mode == dtti_pkg::MODE_S32;
            if (is_digit)
                add_digit(item.char_in);
            else if (is_sign && signed_mode)
            begin
                negative = item.char_in == dtti_pkg::CHAR_MINUS;
                phase = AFTER_SIGN;
            end
            else
                phase = FAILED;
        end
        else if (phase == AFTER_SIGN || phase == IN_DIGITS)
        begin
            if (is_digit)
                add_digit(item.char_in);
            else
                phase = FAILED;
        end
        if (!item.last_char)
            return 1'b0;
        good = phase == IN_DIGITS && !overflowed;
        if (good && string_mode == dtti_pkg::MODE_S32)
            good = negative ? magnitude <= 64'h8000_0000 : magnitude <= 64'h7FFF_FFFF;
        else if (good && string_mode == dtti_pkg::MODE_U32)
            good = magnitude <= 64'hFFFF_FFFF;
        res.ok = good;
        if (good)
            res.number = negative ? -magnitude : magnitude;
        clear_string();
        return 1'b1;
    endfunction

    task automatic send_char(input dtti_pkg::in_t item, output bit has_res,
                             output dtti_pkg::out_t res);
        while (!steady && $urandom_range(99) < 32)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        do @(posedge clk); while (!in_ready);
        has_res = parse_char(item, res);
        chars_sent++;
    endtask

    task automatic send_text(input logic [7:0] text[$], input dtti_pkg::mode_t m);
        dtti_pkg::in_t  item;
        bit             has_res;
        dtti_pkg::out_t res;
        for (int i = 0; i < text.size(); i++)
        begin
            item.char_in = text[i];
            item.last_char = i == text.size() - 1;
            item.mode = (i == 0) ? m : dtti_pkg::mode_t'($urandom_range(3));
            send_char(item, has_res, res);
            if (has_res)
                expected_results.push_back(res);
        end
    endtask

    task automatic random_string();
        logic [7:0]      text[$];
        logic [63:0]     value;
        dtti_pkg::mode_t m;
        int              kind;
        int              width;
        m = dtti_pkg::mode_t'($urandom_range(3));
        kind = $urandom_range(99);
        if (kind < 18)
        begin
            case ($urandom_range(11))
                0: value = 64'd0;
                1: value = 64'd1;
                2: value = 64'h7FFF_FFFF;
                3: value = 64'h8000_0000;
                4: value = 64'h8000_0001;
                5: value = 64'hFFFF_FFFF;
                6: value = 64'h1_0000_0000;
                7: value = MAG_MAX - 64'd1;
                8: value = MAG_MAX;
                9: value = MAG_MAX + 64'd1;
                10: value = 64'hFFFF_FFFF_FFFF_FFFF;
                default: value = 64'(MAG_MAX / 64'd10);
            endcase
        end
        else
        begin
            width = $urandom_range(1, 64);
            value = {$urandom, $urandom} >> (64 - width);
        end
        if (kind >= 80)
        begin
            // raw digit run, may pass 2^64
            repeat ($urandom_range(1, 22))
                text.push_back(dtti_pkg::CHAR_ZERO + 8'($urandom_range(9)));
        end
        else
        begin
            do
            begin
                text.push_front(dtti_pkg::CHAR_ZERO + 8'(value % 64'd10));
                value = value / 64'd10;
            end while (value != 0);
        end
        if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 3)) text.push_front(dtti_pkg::CHAR_ZERO);
        if ((m == dtti_pkg::MODE_S64 || m == dtti_pkg::MODE_S32)
                ? $urandom_range(1) == 1 : $urandom_range(29) == 0)
            text.push_front($urandom_range(1) ? dtti_pkg::CHAR_MINUS : dtti_pkg::CHAR_PLUS);
        kind = $urandom_range(99);
        if (kind < 10)
            text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
        else if (kind < 13)
            text = '{$urandom_range(1) ? dtti_pkg::CHAR_MINUS : dtti_pkg::CHAR_PLUS};
        else if (kind < 16)
            text = '{8'($urandom_range(255))};
        send_text(text, m);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected transfer: ok %0d number %0d",
                       out_data.ok, out_data.number);
                error_count++;
            end
            else
            begin
                oldest = expected_results.pop_front();
                if (out_data.ok !== oldest.ok)
                begin
                    $error("ok: expected %0d, actual %0d", oldest.ok, out_data.ok);
                    error_count++;
                end
                if (out_data.number !== oldest.number)
                begin
                    $error("number: expected %0d, actual %0d",
                           oldest.number, out_data.number);
                    error_count++;
                end
            end
        end
        out_ready <= steady || $urandom_range(99) >= 32;
    end

    initial
    begin
        dtti_pkg::in_t  item;
        bit             has_res;
        dtti_pkg::out_t res;
        dtti_pkg::out_t typed_res;
        clear_string();
        string_mode = dtti_pkg::MODE_S64;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            item.char_in = directed[i].ch;
            item.last_char = directed[i].last;
            item.mode = directed[i].mode;
            send_char(item, has_res, res);
            if (has_res)
            begin
                typed_res.ok = directed[i].ok;
                typed_res.number = directed[i].num;
                expected_results.push_back(directed[i].typed ? typed_res : res);
            end
        end
        while (chars_sent < DIRECTED_ROWS + RANDOM_CHARS)
        begin
            steady = chars_sent >= 600 && chars_sent < 900;
            random_string();
        end
        steady = 1'b0;
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
